[rtl/first_fit_arena_allocator_core_defines.svh]
// assertion macros for the allocator
`ifndef FIRST_FIT_ARENA_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FFA_ASSERT(label, clk, rst_n, prop, msg)
`define FFA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/ffa_pkg.sv]
package ffa_pkg;
    localparam int ArenaBytes = 65536;
    localparam int MaxBlocks  = 256;
    localparam int IdxW       = $clog2(MaxBlocks);
    localparam int CntW       = $clog2(MaxBlocks + 1);
    localparam logic [16:0] HeaderBytes = 17'd12;
    localparam logic [16:0] StartWord   = 17'd4;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_OTHER = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic search_start;
        logic search_step;
        logic insert_write;
        logic shift_step;
        logic remove_step;
        logic stat_start;
        logic stat_step;
        logic stat_end;
        logic mem_read;
        logic rd_prev;
        logic rd_next;
    } dp_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic table_full;
        logic search_done;
        logic search_found;
        logic shift_done;
        logic remove_done;
        logic stat_done;
    } dp_stat_t;
endpackage

[rtl/ffa_datapath.sv]
`include "first_fit_arena_allocator_core_defines.svh"
module ffa_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffa_pkg::dp_cmd_t     cmd,
    output ffa_pkg::dp_stat_t    stat,
    input  logic                 cfg_we,
    input  logic [16:0]          cfg_wdata,
    input  logic [1:0]           mode,
    input  logic [15:0]          request_size,
    input  logic [15:0]          block_address,
    output logic [15:0]          result_address,
    output logic [1:0]           status,
    output logic [8:0]           used_blocks,
    output logic [16:0]          used_payload_bytes,
    output logic [8:0]           free_gaps,
    output logic [15:0]          free_bytes
);
    import ffa_pkg::*;

    logic [15:0] start_mem [MaxBlocks];
    logic [16:0] foot_mem  [MaxBlocks];
    logic [15:0] rd_start;
    logic [16:0] rd_foot;

    logic [16:0]     arena_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] idx_reg;
    logic [1:0]      mode_reg;
    logic [15:0]     size_reg;
    logic [15:0]     addr_reg;
    logic [17:0]     prev_end_reg;
    logic [1:0]      status_reg;
    logic [15:0]     result_reg;
    logic [17:0]     payload_reg;
    logic [17:0]     used_reg;
    logic [CntW:0]   gaps_reg;
    logic            found_hit;
    logic            addr_hit;
    logic            search_hit;
    logic            at_end;
    logic [16:0]     eff;
    logic [16:0]     total;
    logic [17:0]     blk_end;
    logic [CntW-1:0] rd_idx;
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic [15:0]     wr_start;
    logic [16:0]     wr_foot;
    logic            end_fit;

    assign eff   = (arena_reg < StartWord) ? StartWord : arena_reg;
    assign total = HeaderBytes + {1'b0, size_reg};
    assign blk_end = {2'b00, rd_start} + {1'b0, rd_foot};

    // read address chosen by phase
    always_comb
    begin
        rd_idx = idx_reg;
        if (cmd.rd_prev)
            rd_idx = idx_reg - CntW'(1);
        else if (cmd.rd_next)
            rd_idx = idx_reg + CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_start <= start_mem[rd_idx[IdxW-1:0]];
            rd_foot  <= foot_mem[rd_idx[IdxW-1:0]];
        end
        if (wr_en)
        begin
            start_mem[wr_idx] <= wr_start;
            foot_mem[wr_idx]  <= wr_foot;
        end
    end

    assign found_hit = ({2'b00, rd_start} >= prev_end_reg) &&
                       (({2'b00, rd_start} - prev_end_reg) >= {1'b0, total});
    assign end_fit = ({1'b0, eff} > prev_end_reg) &&
                     (({1'b0, eff} - prev_end_reg) >= {1'b0, total}) &&
                     (prev_end_reg + {1'b0, HeaderBytes} <= 18'hFFFF);
    assign addr_hit   = ({2'b00, rd_start} + 18'(HeaderBytes) == {2'b00, addr_reg});
    assign search_hit = (mode_reg == MODE_ALLOC) ? found_hit : addr_hit;
    assign at_end     = (idx_reg == count_reg);

    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = idx_reg[IdxW-1:0];
        wr_start = rd_start;
        wr_foot  = rd_foot;
        if (cmd.insert_write)
        begin
            wr_en    = 1'b1;
            wr_start = prev_end_reg[15:0];
            wr_foot  = total;
        end
        else if (cmd.shift_step || cmd.remove_step)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg    <= 17'(ArenaBytes);
            count_reg    <= '0;
            idx_reg      <= '0;
            mode_reg     <= '0;
            size_reg     <= '0;
            addr_reg     <= '0;
            prev_end_reg <= '0;
            status_reg   <= ST_OK;
            result_reg   <= '0;
            payload_reg  <= '0;
            used_reg     <= '0;
            gaps_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                arena_reg <= (cfg_wdata > 17'(ArenaBytes)) ? 17'(ArenaBytes) : cfg_wdata;
            if (cmd.load)
            begin
                mode_reg   <= mode;
                size_reg   <= request_size;
                addr_reg   <= block_address;
                status_reg <= ST_OK;
                result_reg <= '0;
            end
            if (cmd.search_start)
            begin
                idx_reg      <= '0;
                prev_end_reg <= 18'(StartWord);
                if (mode_reg == MODE_ALLOC && count_reg >= CntW'(MaxBlocks))
                    status_reg <= ST_NO_SPACE;
            end
            if (cmd.search_step)
            begin
                if (at_end)
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (!end_fit)
                            status_reg <= ST_NO_SPACE;
                    end
                    else
                        status_reg <= ST_NOT_FOUND;
                end
                else if (mode_reg == MODE_ALLOC && found_hit)
                    idx_reg <= count_reg;
                else if (mode_reg != MODE_ALLOC && addr_hit)
                    count_reg <= count_reg - CntW'(1);
                else
                begin
                    prev_end_reg <= blk_end;
                    idx_reg      <= idx_reg + CntW'(1);
                end
            end
            if (cmd.insert_write)
            begin
                result_reg <= 16'(prev_end_reg + 18'(HeaderBytes));
                count_reg  <= count_reg + CntW'(1);
            end
            if (cmd.shift_step)
                idx_reg <= idx_reg - CntW'(1);
            if (cmd.remove_step)
                idx_reg <= idx_reg + CntW'(1);
            if (cmd.stat_start)
            begin
                idx_reg      <= '0;
                prev_end_reg <= 18'(StartWord);
                payload_reg  <= '0;
                used_reg     <= 18'(StartWord);
                gaps_reg     <= '0;
            end
            if (cmd.stat_step)
            begin
                if ({2'b00, rd_start} > prev_end_reg)
                    gaps_reg <= gaps_reg + (CntW+1)'(1);
                prev_end_reg <= blk_end;
                payload_reg  <= payload_reg + {1'b0, rd_foot} - 18'(HeaderBytes);
                used_reg     <= used_reg + {1'b0, rd_foot};
                idx_reg      <= idx_reg + CntW'(1);
            end
            if (cmd.stat_end)
            begin
                if ({1'b0, eff} > prev_end_reg)
                    gaps_reg <= gaps_reg + (CntW+1)'(1);
            end
        end
    end

    // shift phase walks down from the table end to the insert point
    logic [CntW-1:0] ins_idx_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.search_step)
            ins_idx_reg <= idx_reg;
    end

    assign stat.is_alloc     = (mode_reg == MODE_ALLOC);
    assign stat.is_free      = (mode_reg == MODE_FREE);
    assign stat.table_full   = (count_reg >= CntW'(MaxBlocks));
    assign stat.search_done  = at_end || search_hit;
    assign stat.search_found = at_end ? ((mode_reg == MODE_ALLOC) && end_fit) : search_hit;
    assign stat.shift_done   = (idx_reg == ins_idx_reg);
    assign stat.remove_done  = (idx_reg >= count_reg);
    assign stat.stat_done    = (idx_reg == count_reg);

    assign result_address     = result_reg;
    assign status             = status_reg;
    assign used_blocks        = 9'(count_reg);
    assign used_payload_bytes = payload_reg[16:0];
    assign free_gaps          = 9'(gaps_reg);
    assign free_bytes         = ({1'b0, eff} > used_reg) ? 16'({1'b0, eff} - used_reg) : 16'd0;

    `FFA_ASSERT(a_count_max, clk, rst_n, (count_reg <= CntW'(MaxBlocks)), "block count overflow")
    `FFA_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.insert_write,
        count_reg == $past(count_reg) + CntW'(1), "insert did not grow table")
    `FFA_ASSERT(a_no_double, clk, rst_n, !(cmd.insert_write && cmd.remove_step),
        "insert and remove together")
endmodule

[rtl/ffa_ctrl.sv]
`include "first_fit_arena_allocator_core_defines.svh"
module ffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ffa_pkg::dp_cmd_t  cmd,
    input  ffa_pkg::dp_stat_t stat
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SRD, S_SCMP, S_INS_RD, S_INS_WR, S_INSERT,
        S_REM_RD, S_REM_WR, S_STAT_INIT, S_STAT_RD, S_STAT_ACC, S_STAT_END, S_OUT
    } state_t;

    state_t state_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:     cmd.load = in_valid;
            S_CHECK:    cmd.search_start = 1'b1;
            S_SRD:      cmd.mem_read = 1'b1;
            S_SCMP:     cmd.search_step = 1'b1;
            S_INS_RD:
            begin
                cmd.mem_read = !stat.shift_done;
                cmd.rd_prev  = 1'b1;
            end
            S_INS_WR:   cmd.shift_step = 1'b1;
            S_INSERT:   cmd.insert_write = 1'b1;
            S_REM_RD:
            begin
                cmd.mem_read = !stat.remove_done;
                cmd.rd_next  = 1'b1;
            end
            S_REM_WR:   cmd.remove_step = 1'b1;
            S_STAT_INIT: cmd.stat_start = 1'b1;
            S_STAT_RD:  cmd.mem_read = 1'b1;
            S_STAT_ACC: cmd.stat_step = 1'b1;
            S_STAT_END: cmd.stat_end = 1'b1;
            S_OUT:      cmd = '0;
            default:    cmd = '0;
        endcase
    end

    // stat_go sends query and other modes from the check state straight to the stat pass
    logic stat_go;
    assign stat_go = (state_reg == S_CHECK && !stat.is_alloc && !stat.is_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_CHECK;
                S_CHECK:
                    if (stat_go || (stat.is_alloc && stat.table_full))
                        state_reg <= S_STAT_INIT;
                    else
                        state_reg <= S_SRD;
                S_SRD:
                    state_reg <= S_SCMP;
                S_SCMP:
                    if (!stat.search_done)
                        state_reg <= S_SRD;
                    else if (!stat.search_found)
                        state_reg <= S_STAT_INIT;
                    else if (stat.is_alloc)
                        state_reg <= S_INS_RD;
                    else
                        state_reg <= S_REM_RD;
                S_INS_RD:
                    state_reg <= stat.shift_done ? S_INSERT : S_INS_WR;
                S_INS_WR:
                    state_reg <= S_INS_RD;
                S_INSERT:
                    state_reg <= S_STAT_INIT;
                S_REM_RD:
                    state_reg <= stat.remove_done ? S_STAT_INIT : S_REM_WR;
                S_REM_WR:
                    state_reg <= S_REM_RD;
                S_STAT_INIT:
                    state_reg <= S_STAT_RD;
                S_STAT_RD:
                    state_reg <= stat.stat_done ? S_STAT_END : S_STAT_ACC;
                S_STAT_ACC:
                    state_reg <= S_STAT_RD;
                S_STAT_END:
                    state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    `FFA_ASSERT(a_excl, clk, rst_n, !(in_ready && out_valid), "ready and valid overlap")
    `FFA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `FFA_ASSERT_NEXT(a_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accept not taken")
endmodule

[rtl/first_fit_arena_allocator_core.sv]
// first-fit allocator over a byte arena, block table held in on-chip memory
// input channel: in_valid/in_ready with mode, request_size, block_address
// output channel: out_valid/out_ready with result_address, status and the
// usage counts (used_blocks, used_payload_bytes, free_gaps, free_bytes)
// arena_size is written with cfg_we/cfg_wdata; the user must write it only
// while no request is in flight, as the block does not enforce it
// one request at a time; a request searches the table, shifts the table on
// insert or remove, and then walks the table for the statistics
// every walk goes through the single table memory port
// reset empties the table and sets the arena to its full size; no
// clearing pass is needed
// a result waits in its registers while out_ready is low; no new request
// is taken until it is accepted
module first_fit_arena_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_address,
    output logic [1:0]  status,
    output logic [8:0]  used_blocks,
    output logic [16:0] used_payload_bytes,
    output logic [8:0]  free_gaps,
    output logic [15:0] free_bytes
);
    import ffa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
    );

    ffa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .mode(mode), .request_size(request_size), .block_address(block_address),
        .result_address(result_address), .status(status),
        .used_blocks(used_blocks), .used_payload_bytes(used_payload_bytes),
        .free_gaps(free_gaps), .free_bytes(free_bytes)
    );
endmodule
